// ----- design/depth_histogram_colorizer_defines.svh -----
// Assertion macros shared by the colorizer RTL.
`ifndef DEPTH_HISTOGRAM_COLORIZER_DEFINES_SVH
`define DEPTH_HISTOGRAM_COLORIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DHC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("colorizer check failed");

// Next-cycle implication, checked outside reset.
`define DHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("colorizer check failed");

`endif

// ----- design/dhc_pkg.sv -----
// Types and constants of the depth histogram colorizer.
`default_nettype none
package dhc_pkg;
    localparam int DEPTH_W = 16;
    localparam int CNT_W   = 21;
    localparam int COLOR_W = 8;
    localparam int CFG_W   = 11;
    localparam int PROD_W  = CNT_W + COLOR_W;

    localparam logic [CFG_W-1:0]   WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0]   HEIGHT_RST = 11'd480;
    localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'd255;
    localparam logic [COLOR_W-1:0] ZERO_RED   = 8'd20;
    localparam logic [COLOR_W-1:0] ZERO_GREEN = 8'd5;
    localparam logic [COLOR_W-1:0] ZERO_BLUE  = 8'd0;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic               fetch;
        logic [DEPTH_W-1:0] depth;
    } t_cmd;
endpackage
`default_nettype wire

// ----- design/dhc_ram.sv -----
// Generic one-write one-read RAM with registered read data.
`default_nettype none
module dhc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/dhc_front.sv -----
// Request intake: tags each word as load or fetch and queues it for the back end.
`default_nettype none
module dhc_front
    import dhc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_req_type,
    input  wire logic [DEPTH_W-1:0] i_depth,
    input  wire logic               i_hold,
    input  wire logic               i_pop,
    output logic                    o_busy,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_busy      = (r_cnt == 2'd2) || i_hold;
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= '{fetch: i_req_type, depth: i_depth};
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// ----- design/dhc_back.sv -----
// Execution engine: histogram update, prefix pass, colorize with divider, clear pass.
`default_nettype none
module dhc_back
    import dhc_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CFG_W-1:0]   i_frame_width,
    input  wire logic [CFG_W-1:0]   i_frame_height,
    input  wire logic               i_cmd_valid,
    input  wire t_cmd               i_cmd,
    output logic                    o_pop,
    output logic                    o_init,
    output logic                    o_valid,
    output logic      [COLOR_W-1:0] o_red,
    output logic      [COLOR_W-1:0] o_green,
    output logic      [COLOR_W-1:0] o_blue,
    output logic                    o_last_pixel
);
    localparam int BINS = 1 << DEPTH_BITS;
    localparam int BW   = DEPTH_BITS;
    localparam int FAW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int FDEP = 1 << FAW;
    localparam int IW   = $clog2(MAX_PIXELS + 1);
    localparam logic [BW:0]   TOP  = (BW + 1)'(BINS - 1);
    localparam logic [IW-1:0] MAXP = IW'(MAX_PIXELS);

    typedef enum logic [3:0] {
        S_INIT_CLR, S_IDLE, S_LD_WR, S_PF, S_F_RD, S_F_MUL, S_F_DIV, S_F_OUT, S_CLR
    } t_state;

    t_state              r_state;
    logic                r_read_phase;
    logic [IW-1:0]       r_load_idx, r_rd_idx, r_npix;
    logic [BW-1:0]       r_dep;
    logic [BW:0]         r_cnt;
    logic                r_pv;
    logic [BW-1:0]       r_pa;
    logic [CNT_W-1:0]    r_acc, r_total;
    logic                r_zero;
    logic [PROD_W-1:0]   r_rem;
    logic [2:0]          r_k;
    logic [COLOR_W-1:0]  r_q;

    logic                h_we;
    logic [BW-1:0]       h_waddr, h_raddr;
    logic [CNT_W-1:0]    h_wdata, h_rdata;
    logic                f_we;
    logic [DEPTH_W-1:0]  f_rdata;
    logic                load_ok, fetch_ok;
    logic [CNT_W-1:0]    pf_sum;
    logic [PROD_W-1:0]   tsh;
    logic                ge;
    logic [IW-1:0]       ld_next, rd_next;
    logic [CFG_W-1:0]    w_eff, h_eff;
    logic [2*CFG_W-1:0]  area;

    assign w_eff    = (i_frame_width == '0) ? CFG_W'(1) : i_frame_width;
    assign h_eff    = (i_frame_height == '0) ? CFG_W'(1) : i_frame_height;
    assign area     = w_eff * h_eff;
    assign load_ok  = !i_cmd.fetch && !r_read_phase && (r_load_idx < MAXP);
    assign fetch_ok = i_cmd.fetch && r_read_phase && (r_rd_idx < MAXP);
    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid;
    assign o_init   = (r_state == S_INIT_CLR);
    assign pf_sum   = r_acc + h_rdata;
    assign tsh      = PROD_W'(r_total) << r_k;
    assign ge       = (r_total != '0) && (r_rem >= tsh);
    assign ld_next  = r_load_idx + IW'(1);
    assign rd_next  = r_rd_idx + IW'(1);
    assign f_we     = o_pop && load_ok;

    always_comb begin
        h_raddr = r_dep;
        h_we    = 1'b0;
        h_waddr = r_dep;
        h_wdata = CNT_W'(h_rdata + 1'b1);
        unique case (r_state)
            S_IDLE:  h_raddr = i_cmd.depth[BW-1:0];
            S_LD_WR: h_we = 1'b1;
            S_PF: begin
                h_raddr = r_cnt[BW-1:0];
                h_we    = r_pv;
                h_waddr = r_pa;
                h_wdata = pf_sum;
            end
            S_F_RD:  h_raddr = f_rdata[BW-1:0];
            S_INIT_CLR, S_CLR: begin
                h_we    = 1'b1;
                h_waddr = r_cnt[BW-1:0];
                h_wdata = '0;
            end
            default: h_we = 1'b0;
        endcase
    end

    dhc_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    dhc_ram #(.WIDTH(DEPTH_W), .DEPTH(FDEP)) u_frame (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(r_load_idx[FAW-1:0]),
        .i_wdata(i_cmd.depth), .i_raddr(r_rd_idx[FAW-1:0]), .o_rdata(f_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT_CLR;
            r_read_phase <= 1'b0;
            r_load_idx   <= '0;
            r_rd_idx     <= '0;
            r_cnt        <= '0;
            r_pv         <= 1'b0;
            o_valid      <= 1'b0;
            r_npix       <= IW'(1);
        end else begin
            o_valid <= 1'b0;
            // saturate the frame size at MAX_PIXELS
            if (32'(area) > 32'(MAX_PIXELS)) begin
                r_npix <= MAXP;
            end else begin
                r_npix <= IW'(area);
            end
            unique case (r_state)
                S_INIT_CLR, S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == TOP) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_dep <= i_cmd.depth[BW-1:0];
                    if (o_pop && load_ok) begin
                        r_state <= S_LD_WR;
                    end else if (o_pop && fetch_ok) begin
                        r_state <= S_F_RD;
                    end
                end
                S_LD_WR: begin
                    r_load_idx <= ld_next;
                    if (ld_next >= r_npix) begin
                        r_state <= S_PF;
                        r_cnt   <= (BW + 1)'(1);
                        r_pv    <= 1'b0;
                        r_acc   <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PF: begin
                    if (r_cnt <= TOP) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_pv  <= 1'b1;
                        r_pa  <= r_cnt[BW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_acc <= pf_sum;
                        if ({1'b0, r_pa} == TOP) begin
                            r_total      <= pf_sum;
                            r_read_phase <= 1'b1;
                            r_rd_idx     <= '0;
                            r_state      <= S_IDLE;
                        end
                    end
                end
                S_F_RD: begin
                    r_zero  <= (f_rdata[BW-1:0] == '0);
                    r_state <= S_F_MUL;
                end
                S_F_MUL: begin
                    r_rem   <= PROD_W'(h_rdata) * PROD_W'(COLOR_MAX);
                    r_k     <= 3'd7;
                    r_q     <= '0;
                    r_state <= r_zero ? S_F_OUT : S_F_DIV;
                end
                S_F_DIV: begin
                    // one quotient bit per cycle, quotient fits in a byte
                    if (ge) begin
                        r_rem    <= r_rem - tsh;
                        r_q[r_k] <= 1'b1;
                    end
                    r_k <= r_k - 1'b1;
                    if (r_k == 3'd0) begin
                        r_state <= S_F_OUT;
                    end
                end
                S_F_OUT: begin
                    o_valid      <= 1'b1;
                    o_red        <= r_zero ? ZERO_RED : COLOR_MAX - r_q;
                    o_green      <= r_zero ? ZERO_GREEN : '0;
                    o_blue       <= r_zero ? ZERO_BLUE : r_q;
                    o_last_pixel <= (rd_next >= r_load_idx);
                    r_rd_idx     <= rd_next;
                    if (rd_next >= r_load_idx) begin
                        r_read_phase <= 1'b0;
                        r_load_idx   <= '0;
                        r_rd_idx     <= '0;
                        r_cnt        <= '0;
                        r_state      <= S_CLR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/depth_histogram_colorizer.sv -----
// Top level of the depth histogram colorizer: config registers, intake queue and engine.
`default_nettype none
// Depth frame colorizer with histogram equalization. Issue a word with i_start while
// o_busy is low: i_req_type 0 loads a depth pixel, 1 fetches the next colored pixel.
// A two-entry queue takes words while the engine works. A load is popped and then
// counted in its histogram bin; the last load of a frame adds a prefix pass over the
// histogram memory. A fetch runs pop, frame store read, histogram read and multiply,
// a bit-per-cycle divider and output, skipping the divider for a zero depth, and
// its color appears for one cycle with o_valid; the receiver cannot stall it. The last
// fetch starts a histogram clear. After reset, o_busy stays high for the histogram
// clear. Loads during readout and fetches with no frame ready are dropped.
module depth_histogram_colorizer
    import dhc_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_req_type,
    input  wire logic [DEPTH_W-1:0] i_depth,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    output logic                    o_valid,
    output logic      [COLOR_W-1:0] o_red,
    output logic      [COLOR_W-1:0] o_green,
    output logic      [COLOR_W-1:0] o_blue,
    output logic                    o_last_pixel
);
`include "depth_histogram_colorizer_defines.svh"

    logic [CFG_W-1:0] r_frame_width, r_frame_height;
    logic             cmd_valid, pop, init;
    t_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_HEIGHT: r_frame_height <= i_cfg_data;
                default:    r_frame_width  <= r_frame_width;
            endcase
        end
    end

    dhc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req_type(i_req_type),
        .i_depth(i_depth), .i_hold(init), .i_pop(pop), .o_busy(o_busy),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd)
    );

    dhc_back #(.MAX_PIXELS(MAX_PIXELS), .DEPTH_BITS(DEPTH_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_frame_width(r_frame_width),
        .i_frame_height(r_frame_height), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_pop(pop), .o_init(init), .o_valid(o_valid), .o_red(o_red),
        .o_green(o_green), .o_blue(o_blue), .o_last_pixel(o_last_pixel)
    );

    `DHC_ASSERT_NEXT(a_pulse_gap, o_valid, !o_valid)
    `DHC_ASSERT_NOW(a_zero_color, o_valid && o_green != '0,
        o_red == ZERO_RED && o_blue == ZERO_BLUE)
    `DHC_ASSERT_NOW(a_no_pop_empty, pop, cmd_valid)
    `DHC_ASSERT_NOW(a_busy_init, init, o_busy && !o_valid)

endmodule
`default_nettype wire
